// File: rtl/core/sliding_window_median_filter_assert.svh
// Assertion macros used by the median filter top level.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define SWMF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("median filter check failed");

// Consequence must hold in the cycle after the antecedent.
`define SWMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("median filter check failed");

`endif

// File: rtl/core/swmf_pkg.sv
// Package for the sliding window median filter: sample type, defaults, link type.
// No dependencies.
package swmf_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int WINDOW_DEFAULT = 5;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Control handed from a cell to the cell above it in sorted order.
    typedef struct packed {
        logic gone;  // the entry being retired sits at or below this cell
        logic fits;  // the compacted entry here is not larger than the new sample
    } link_t;

endpackage

// File: rtl/core/sliding_window_median_filter.sv
// Top level of the sliding window median filter: a chain of sorted cells.
// Depends on swmf_pkg, swmf_cell and sliding_window_median_filter_assert.svh.
//
//   channel   signals                          payload
//   input     sample_valid / sample_ready      sample (signed 16 bits)
//   output    median_valid / median_ready      median (signed 16 bits)
//
// One request is taken per cycle while the output is not stalled; its median appears in the cycle after acceptance.
// The cells keep the window sorted, each tagged with its age; a request retires
// the oldest entry and inserts the new sample in one pass along the cell chain.
// Reset clears every entry to zero, so early medians include those zeros.
// A stalled result sits in the output register while a new request is taken
// in the same cycle that the waiting result is taken.
`include "sliding_window_median_filter_assert.svh"

module sliding_window_median_filter #(
    parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  swmf_pkg::sample_t sample,
    output logic              median_valid,
    input  logic              median_ready,
    output swmf_pkg::sample_t median
);

    localparam int AGE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MID   = WINDOW / 2;

    logic                                 accept;
    swmf_pkg::link_t                      link [0:WINDOW];
    swmf_pkg::sample_t                    compact_value [0:WINDOW-1];
    logic [AGE_W-1:0]                     compact_age [0:WINDOW-1];
    swmf_pkg::sample_t                    value_next [0:WINDOW-1];
    logic [WINDOW-1:0][swmf_pkg::SAMPLE_W-1:0] value_all;
    logic [WINDOW-1:0][AGE_W-1:0]         age_all;
    logic [WINDOW-1:0]                    oldest;
    logic [WINDOW-1:0]                    sorted_ok;
    swmf_pkg::sample_t                    median_reg;
    logic                                 median_valid_reg;

    // A new request is taken whenever the output register is empty or draining.
    assign sample_ready = !median_valid_reg || median_ready;
    assign accept       = sample_valid && sample_ready;

    // The bottom cell has nothing retired below it and everything below fits.
    assign link[0] = '{gone: 1'b0, fits: 1'b1};

    // Chain of cells, smallest entry at index zero.
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        swmf_pkg::sample_t lower_value;
        logic [AGE_W-1:0]  lower_age;
        swmf_pkg::sample_t upper_value;
        logic [AGE_W-1:0]  upper_age;

        if (i == 0)
        begin : g_bottom
            assign lower_value = sample;
            assign lower_age   = '0;
        end
        else
        begin : g_inner_low
            assign lower_value = compact_value[i-1];
            assign lower_age   = compact_age[i-1];
        end

        if (i == WINDOW - 1)
        begin : g_top
            assign upper_value = '0;
            assign upper_age   = '0;
        end
        else
        begin : g_inner_high
            assign upper_value = value_all[i+1];
            assign upper_age   = age_all[i+1];
        end

        swmf_cell #(
            .WINDOW  (WINDOW),
            .AGE_W   (AGE_W),
            .INDEX   (i),
            .IS_LAST (i == WINDOW - 1)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .load          (accept),
            .sample        (sample),
            .link_in       (link[i]),
            .lower_value   (lower_value),
            .lower_age     (lower_age),
            .upper_value   (upper_value),
            .upper_age     (upper_age),
            .link_out      (link[i+1]),
            .compact_value (compact_value[i]),
            .compact_age   (compact_age[i]),
            .value         (value_all[i]),
            .age           (age_all[i]),
            .value_next    (value_next[i]),
            .oldest        (oldest[i])
        );

        // Adjacent entries stay in ascending order.
        if (i == WINDOW - 1)
        begin : g_sorted_top
            assign sorted_ok[i] = 1'b1;
        end
        else
        begin : g_sorted_pair
            assign sorted_ok[i] = $signed(value_all[i]) <= $signed(value_all[i+1]);
        end
    end

    // Output register holds the median until the downstream takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            median_valid_reg <= 1'b1;
        end
        else if (median_ready)
        begin
            median_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            median_reg <= value_next[MID];
        end
    end

    assign median_valid = median_valid_reg;
    assign median       = median_reg;

    // Every request yields a result on the next cycle.
    `SWMF_ASSERT_NEXT(a_result_follows, accept, median_valid)
    // Exactly one entry is the oldest, so the ages form a permutation.
    `SWMF_ASSERT_ALWAYS(a_one_oldest, $onehot(oldest))
    // The retired entry is always found somewhere along the chain.
    `SWMF_ASSERT_ALWAYS(a_retire_found, link[WINDOW].gone)
    // The window stays sorted.
    `SWMF_ASSERT_ALWAYS(a_sorted, &sorted_ok)
    // Without a request the window does not change.
    `SWMF_ASSERT_NEXT(a_hold_idle, !accept, $stable(value_all) && $stable(age_all))

endmodule

// File: rtl/core/swmf_cell.sv
// One cell of the sorted window: holds one entry and its age.
// Depends on swmf_pkg.
module swmf_cell #(
    parameter int WINDOW  = swmf_pkg::WINDOW_DEFAULT,
    parameter int AGE_W   = 1,
    parameter int INDEX   = 0,
    parameter bit IS_LAST = 1'b0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  swmf_pkg::sample_t   sample,
    input  swmf_pkg::link_t     link_in,
    input  swmf_pkg::sample_t   lower_value,
    input  logic [AGE_W-1:0]    lower_age,
    input  swmf_pkg::sample_t   upper_value,
    input  logic [AGE_W-1:0]    upper_age,
    output swmf_pkg::link_t     link_out,
    output swmf_pkg::sample_t   compact_value,
    output logic [AGE_W-1:0]    compact_age,
    output swmf_pkg::sample_t   value,
    output logic [AGE_W-1:0]    age,
    output swmf_pkg::sample_t   value_next,
    output logic                oldest
);

    swmf_pkg::sample_t  value_reg;
    logic [AGE_W-1:0]   age_reg;
    logic [AGE_W-1:0]   age_next;

    // The oldest entry is the one retired by the next request.
    assign oldest = (age_reg == AGE_W'(WINDOW - 1));

    // Close the gap left by the retired entry by pulling the upper neighbor down.
    assign link_out.gone = link_in.gone | oldest;
    assign compact_value = link_out.gone ? upper_value : value_reg;
    assign compact_age   = link_out.gone ? upper_age   : age_reg;

    // The top cell has no compacted entry of its own.
    assign link_out.fits = IS_LAST ? 1'b0 : (compact_value <= sample);

    // Keep the compacted entry, take the new sample, or shift up from below.
    always_comb
    begin
        if (link_out.fits)
        begin
            value_next = compact_value;
            age_next   = compact_age + AGE_W'(1);
        end
        else if (link_in.fits)
        begin
            value_next = sample;
            age_next   = '0;
        end
        else
        begin
            value_next = lower_value;
            age_next   = lower_age + AGE_W'(1);
        end
    end

    // Entry and age registers; reset gives a window of zeros with distinct ages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            age_reg   <= AGE_W'(INDEX);
        end
        else if (load)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign value = value_reg;
    assign age   = age_reg;

endmodule

// File: verif/sliding_window_median_filter_test.sv
// Self-checking bench for the sliding window median filter: sample requests go in
// through a queue, and each median is checked against a running-median predictor.
// Depends on swmf_pkg and the sliding_window_median_filter RTL.
module sliding_window_median_filter_test;

    localparam int WINDOW       = swmf_pkg::WINDOW_DEFAULT;
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_STALL   = 300;
    localparam int TAIL_CYCLES  = 10;
    localparam int PHASE_ITEMS  = 360;
    localparam int MAX_REPORTS  = 10;

    // Opening sequence: start-up with zeros in the window, both extremes, and ties.
    localparam swmf_pkg::sample_t OPENING_SAMPLES [25] = '{
        16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sd32768, -16'sd32768,
        -16'sd32768, -16'sd32768, -16'sd32768, 16'sd0, -16'sd1,
        16'sd1, 16'sd7, 16'sd7, 16'sd7, 16'sd7,
        -16'sd5, 16'sd3, 16'sd3, 16'sd20, -16'sd20,
        16'sh7FFF, -16'sd32768, 16'sd0, 16'sd12, 16'sd11
    };

    typedef enum int {ANY_VALUE, NEAR_ZERO, REPEAT_LAST, EXTREME, RAMP} sample_pattern_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_ready;
    swmf_pkg::sample_t sample = '0;
    logic              median_valid;
    logic              median_ready = 1'b0;
    swmf_pkg::sample_t median;

    // Predictor state: the window contents and the next slot to overwrite.
    swmf_pkg::sample_t window_copy [WINDOW];
    int                next_slot = 0;

    swmf_pkg::sample_t median_due [$];
    swmf_pkg::sample_t pending_samples [$];

    int   sender_idle_pct = 0;
    int   receiver_idle_pct = 0;
    logic sample_taken = 1'b0;
    bit   long_stall_req = 1'b0;
    int   stall_left = 0;
    int   error_count = 0;
    int   quiet_cycles = 0;

    sliding_window_median_filter #(
        .WINDOW(WINDOW)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample(sample),
        .median_valid(median_valid),
        .median_ready(median_ready),
        .median(median)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Overwrite the oldest entry with the new sample and return the median of the window,
    // that is, the entry at sorted position WINDOW/2 counted from the smallest.
    function automatic swmf_pkg::sample_t slide_in_sample(swmf_pkg::sample_t new_sample);
        swmf_pkg::sample_t sorted [WINDOW];
        swmf_pkg::sample_t key;
        int                j;
        window_copy[next_slot] = new_sample;
        next_slot = (next_slot + 1) % WINDOW;
        sorted = window_copy;
        for (int i = 1; i < WINDOW; i++)
        begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key)
            begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        return sorted[WINDOW / 2];
    endfunction

    // Random samples in short runs of one pattern each, so that the window sees
    // repeated values, clusters near zero, extremes and slow ramps as well as noise.
    task automatic queue_random_samples(input int count);
        swmf_pkg::sample_t last_value;
        sample_pattern_t   pattern;
        int                run;
        last_value = '0;
        while (count > 0)
        begin
            pattern = sample_pattern_t'($urandom_range(4));
            run = $urandom_range(1, 8);
            for (int i = 0; i < run && count > 0; i++)
            begin
                case (pattern)
                    ANY_VALUE:   last_value = swmf_pkg::sample_t'($urandom);
                    NEAR_ZERO:
                        last_value = swmf_pkg::sample_t'(int'($urandom_range(16)) - 8);
                    REPEAT_LAST: last_value = last_value;
                    EXTREME:
                    begin
                        case ($urandom_range(3))
                            0:       last_value = swmf_pkg::sample_t'(16'h7FFF);
                            1:       last_value = swmf_pkg::sample_t'(16'h8000);
                            2:       last_value = '0;
                            default: last_value = '1;
                        endcase
                    end
                    default:
                        last_value = last_value
                                     + swmf_pkg::sample_t'(int'($urandom_range(6)) - 3);
                endcase
                pending_samples.push_back(last_value);
                count--;
            end
        end
    endtask

    // Returns once every queued request has been taken and every median has come back.
    task automatic wait_until_drained();
        while (pending_samples.size() != 0 || sample_valid || median_due.size() != 0)
            @(posedge clk);
    endtask

    // Request driver: holds a request until it is taken, then offers the next one
    // unless the sender idles this cycle.
    always @(negedge clk)
    begin
        logic              offer;
        swmf_pkg::sample_t next_sample;
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else if (!(sample_valid && !sample_taken))
        begin
            offer = 1'b0;
            next_sample = sample;
            if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                offer = 1'b1;
                next_sample = pending_samples.pop_front();
            end
            sample_valid <= offer;
            sample <= next_sample;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off counted here.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            median_ready <= 1'b0;
        end
        else
        begin
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                median_ready <= 1'b0;
            end
            else
            begin
                median_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // Monitor: predicts a median for each request that is taken, and checks each
    // delivered median against the oldest prediction.
    always @(posedge clk)
    begin
        swmf_pkg::sample_t expected_median;
        if (!rst_n)
        begin
            sample_taken <= 1'b0;
        end
        else
        begin
            sample_taken <= sample_valid && sample_ready;
            if (sample_valid && sample_ready)
                median_due.push_back(slide_in_sample(sample));

            if (median_valid && median_ready)
            begin
                if (median_due.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("ERROR: median %0d delivered with no request outstanding",
                                 median);
                end
                else
                begin
                    expected_median = median_due.pop_front();
                    if (median !== expected_median)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("ERROR: median mismatch, expected %0d got %0d",
                                     expected_median, median);
                    end
                end
            end

            // Watchdog: work is outstanding but neither channel moves.
            if ((sample_valid && sample_ready) || (median_valid && median_ready))
                quiet_cycles = 0;
            else if (sample_valid || median_due.size() != 0)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stimulus phases: the opening sequence, then random samples under three idling mixes.
    initial
    begin
        foreach (window_copy[i])
            window_copy[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles often and the receiver stalls often.
        sender_idle_pct = 38;
        receiver_idle_pct = 45;
        foreach (OPENING_SAMPLES[i])
            pending_samples.push_back(OPENING_SAMPLES[i]);
        wait_until_drained();
        queue_random_samples(PHASE_ITEMS);
        wait_until_drained();

        // The same with the two sides swapped.
        sender_idle_pct = 45;
        receiver_idle_pct = 38;
        queue_random_samples(PHASE_ITEMS);
        wait_until_drained();

        // Full rate on both sides, broken once by a long receiver hold-off
        // while the sender keeps offering requests.
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        queue_random_samples(PHASE_ITEMS);
        repeat (20) @(posedge clk);
        long_stall_req = 1'b1;
        wait_until_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (median_due.size() != 0)
        begin
            error_count++;
            $display("ERROR: %0d medians never delivered", median_due.size());
        end
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
